// ===== hw/rtl/ring_entry_offset_lookup_assert.svh =====
// Assertion macros shared by the ring entry offset lookup RTL.
// Depends on nothing; the macros compile to nothing when SYNTH is defined.
`ifndef RING_ENTRY_OFFSET_LOOKUP_ASSERT_SVH
`define RING_ENTRY_OFFSET_LOOKUP_ASSERT_SVH

`ifndef SYNTH

`define REOL_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("same-cycle check failed");

`define REOL_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("next-cycle check failed");

`else

`define REOL_ASSERT_SAME(label, clk, rst, cond, expr)

`define REOL_ASSERT_NEXT(label, clk, rst, cond, expr)

`endif

`endif

// ===== hw/rtl/reol_pkg.sv =====
// Types, constants and helper functions of the ring entry offset lookup.
// Used by the top level; depends on nothing.
package reol_pkg;

   localparam int DEPTH      = 16;
   localparam int SLOT_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int HANDLE_W   = 32;
   localparam int LENGTH_W   = 16;
   localparam int OFFSET_W   = 20;
   localparam int HIT_SLOT_W = 4;
   localparam int ENTRY_W    = HANDLE_W + LENGTH_W;
   localparam int SUM_W      = (LENGTH_W + CNT_W > OFFSET_W) ? LENGTH_W + CNT_W : OFFSET_W;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 56;

   localparam logic KIND_ADD  = 1'b0;
   localparam logic KIND_FIND = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] i);
      next_slot = (i == SLOT_W'(DEPTH - 1)) ? '0 : i + 1'b1;
   endfunction

endpackage

// ===== hw/rtl/reol_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module reol_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ring_entry_offset_lookup.sv =====
// Top level of the ring entry offset lookup: index control, find walk, result register.
// Depends on reol_pkg, reol_ram and ring_entry_offset_lookup_assert.svh.
//
// Channel  Dir  Handshake                 Contents
// req_     in   req_tvalid / req_tready   tuser: kind; tdata: handle, length, offset
// rsp_     out  rsp_tvalid / rsp_tready   tuser: found; tdata: handle, slot, byte offset
//
// An add completes without leaving the idle state. A find walks at most DEPTH
// entries, reading one stored length per cycle from the entry RAM; an empty ring
// skips the walk and answers a miss. Input is taken only when idle.
// Reset clears the indices, the full flag and the control state; the RAM is not cleared.
// A finished result waits in a hold register while the output register is occupied.
`include "ring_entry_offset_lookup_assert.svh"

module ring_entry_offset_lookup import reol_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [31:0] entry_handle, [47:32] entry_length, [67:48] find_offset, [71:68] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] kind
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [31:0] hit_handle, [35:32] hit_slot, [51:36] byte_offset, [55:52] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // [0] found
   output logic                  rsp_tuser
);

   state_type state_ff, state_in;

   logic [SLOT_W-1:0]   write_index_ff, write_index_in;
   logic [SLOT_W-1:0]   read_index_ff, read_index_in;
   logic                full_ff, full_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic [SUM_W-1:0]    total_ff, total_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   logic                  res_found_ff, res_found_in;
   logic [HANDLE_W-1:0]   res_handle_ff, res_handle_in;
   logic [HIT_SLOT_W-1:0] res_slot_ff, res_slot_in;
   logic [LENGTH_W-1:0]   res_boff_ff, res_boff_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [HANDLE_W-1:0]   rsp_handle_ff, rsp_handle_in;
   logic [HIT_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [LENGTH_W-1:0]   rsp_boff_ff, rsp_boff_in;

   logic                req_accept;
   logic                out_free;
   logic [HANDLE_W-1:0] in_handle;
   logic [LENGTH_W-1:0] in_length;
   logic [OFFSET_W-1:0] in_offset;
   logic [CNT_W-1:0]    count;
   logic [SLOT_W-1:0]   wr_next, rd_next;

   logic                ram_wr_en;
   logic [SLOT_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0]  ram_rd_data;
   logic [HANDLE_W-1:0] walk_handle;
   logic [LENGTH_W-1:0] walk_length;
   logic [SUM_W-1:0]    walk_total;
   logic                walk_hit;

   assign in_handle = req_tdata[HANDLE_W-1:0];
   assign in_length = req_tdata[HANDLE_W+LENGTH_W-1:HANDLE_W];
   assign in_offset = req_tdata[ENTRY_W+OFFSET_W-1:ENTRY_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (full_ff) begin
         count = CNT_W'(DEPTH);
      end else if (write_index_ff >= read_index_ff) begin
         count = CNT_W'(write_index_ff - read_index_ff);
      end else begin
         count = CNT_W'(DEPTH) - CNT_W'(read_index_ff) + CNT_W'(write_index_ff);
      end
   end

   assign wr_next = next_slot(write_index_ff);
   assign rd_next = next_slot(read_index_ff);

   // Writes happen only on an accepted add and read data is used only for a find, so
   // no write lands on a read whose data is used and no forwarding is needed.
   assign ram_wr_en   = req_accept && (req_tuser == KIND_ADD);
   assign ram_rd_addr = (state_ff == ST_WALK) ? next_slot(idx_ff) : read_index_ff;

   reol_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (write_index_ff),
      .wr_data ({in_length, in_handle}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign walk_handle = ram_rd_data[HANDLE_W-1:0];
   assign walk_length = ram_rd_data[ENTRY_W-1:HANDLE_W];
   assign walk_total  = total_ff + SUM_W'(walk_length);
   assign walk_hit    = walk_total > SUM_W'(offset_ff);

   always_comb begin
      state_in       = state_ff;
      write_index_in = write_index_ff;
      read_index_in  = read_index_ff;
      full_in        = full_ff;
      idx_in         = idx_ff;
      left_in        = left_ff;
      total_in       = total_ff;
      offset_in      = offset_ff;
      res_found_in   = res_found_ff;
      res_handle_in  = res_handle_ff;
      res_slot_in    = res_slot_ff;
      res_boff_in    = res_boff_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_found_in   = rsp_found_ff;
      rsp_handle_in  = rsp_handle_ff;
      rsp_slot_in    = rsp_slot_ff;
      rsp_boff_in    = rsp_boff_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == KIND_ADD) begin
                  write_index_in = wr_next;
                  if (full_ff) begin
                     read_index_in = rd_next;
                     full_in       = 1'b1;
                  end else if (wr_next == read_index_ff) begin
                     full_in = 1'b1;
                  end
               end else begin
                  idx_in    = read_index_ff;
                  left_in   = count;
                  total_in  = '0;
                  offset_in = in_offset;
                  if (count == '0) begin
                     res_found_in  = 1'b0;
                     res_handle_in = '0;
                     res_slot_in   = '0;
                     res_boff_in   = '0;
                     state_in      = ST_HOLD;
                  end else begin
                     state_in = ST_WALK;
                  end
               end
            end
         end
         ST_WALK: begin
            if (walk_hit) begin
               res_found_in  = 1'b1;
               res_handle_in = walk_handle;
               res_slot_in   = HIT_SLOT_W'(idx_ff);
               res_boff_in   = LENGTH_W'(SUM_W'(offset_ff) - total_ff);
               state_in      = ST_HOLD;
            end else if (left_ff == CNT_W'(1)) begin
               res_found_in  = 1'b0;
               res_handle_in = '0;
               res_slot_in   = '0;
               res_boff_in   = '0;
               state_in      = ST_HOLD;
            end else begin
               total_in = walk_total;
               idx_in   = next_slot(idx_ff);
               left_in  = left_ff - 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_found_in  = res_found_ff;
               rsp_handle_in = res_handle_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_boff_in   = res_boff_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         write_index_ff <= '0;
         read_index_ff  <= '0;
         full_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_index_ff <= write_index_in;
         read_index_ff  <= read_index_in;
         full_ff        <= full_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      left_ff       <= left_in;
      total_ff      <= total_in;
      offset_ff     <= offset_in;
      res_found_ff  <= res_found_in;
      res_handle_ff <= res_handle_in;
      res_slot_ff   <= res_slot_in;
      res_boff_ff   <= res_boff_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_boff_ff   <= rsp_boff_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_boff_ff, rsp_slot_ff, rsp_handle_ff});

   `REOL_ASSERT_SAME(a_walk_has_entries, clock, reset, state_ff == ST_WALK, left_ff != '0)
   `REOL_ASSERT_NEXT(a_hold_loads_output, clock, reset,
      (state_ff == ST_HOLD) && out_free, rsp_valid_ff && (state_ff == ST_IDLE))
   `REOL_ASSERT_SAME(a_miss_is_zero, clock, reset, rsp_valid_ff && !rsp_found_ff,
      (rsp_handle_ff == '0) && (rsp_slot_ff == '0) && (rsp_boff_ff == '0))
   `REOL_ASSERT_NEXT(a_full_add_moves_read, clock, reset,
      req_accept && (req_tuser == KIND_ADD) && full_ff,
      full_ff && (read_index_ff == next_slot($past(read_index_ff))))

endmodule
